FILE: rtl/gels_pkg.sv
// Shared constants and line tables for the Gaussian emission-line synthesiser.
package gels_pkg;

  localparam int unsigned LAMPS      = 2;
  localparam int unsigned TABLE_LINES = 5;
  localparam int unsigned DIV_BITS   = 21;   // quotient bits of the Q.16 exponent
  localparam int unsigned LANE_DEPTH = 26;   // register stages inside one line lane
  localparam int unsigned GELS_LATENCY = 28; // accept edge to result edge

  localparam logic [15:0] MIN_WIDTH   = 16'd16;
  localparam logic [15:0] RST_WIDTH   = 16'd512;
  localparam logic [4:0]  CUTOFF_INT  = 5'd26;

  localparam logic [1:0] REG_LAMP  = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;

  localparam logic [15:0] LINE_CENTRE [LAMPS][TABLE_LINES] = '{
    '{16'd25901, 16'd27891, 16'd34950, 16'd36928, 16'd37062},
    '{16'd37453, 16'd39315, 16'd40973, 16'd45005, 16'd0}
  };

  localparam logic [14:0] LINE_GAIN [LAMPS][TABLE_LINES] = '{
    '{15'd5898, 15'd11469, 15'd16384, 15'd7373, 15'd6881},
    '{15'd8192, 15'd11469, 15'd16384, 15'd9830, 15'd0}
  };

  localparam logic [2:0] LINE_COUNT [LAMPS] = '{3'd5, 3'd4};

endpackage

FILE: rtl/gaussian_emission_line_synth.sv
// Top level of the Gaussian emission-line lamp synthesiser.
// A word on in_wavelength (unsigned Q10.6 nm) is taken at every rising edge
// at which start is high and busy is low. Busy is high only while reset is
// held, so one word may enter in every cycle.
// Each word yields one flux word (unsigned Q2.14, saturating) on out_flux,
// marked by out_valid for exactly one cycle.
// The receiver cannot stall the block, so nothing ever backs up.
// The word passes through the per-line pipeline: one stage for the squared
// distance, one for the six-sigma cut-off test, 21 restoring division stages
// forming the exponent in Q.16, then table lookup, gain multiply and the
// rounded shift, followed by the saturating line sum.
// Every line of the selected lamp, up to MAX_LINES, has a parallel lane.
// Configuration is written through cfg_we, cfg_index and cfg_wdata: index 0
// selects the lamp, index 1 sets the line width in Q8.8 nm. Writes must be
// made only while the block is idle; the block does not enforce this. Reset
// selects the mercury lamp with a width of 2 nm and empties the pipeline.
module gaussian_emission_line_synth import gels_pkg::*; #(
  parameter int unsigned MAX_LINES       = 5,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_wavelength,
  output logic        out_valid,
  output logic [15:0] out_flux,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned NL = (MAX_LINES < TABLE_LINES) ? MAX_LINES : TABLE_LINES;

  logic        lamp_r;
  logic [15:0] width_r;
  logic [15:0] eff_width;
  logic [31:0] wsq_r;
  logic [15:0] wl_r;
  logic        vld_r [LANE_DEPTH+1];
  logic        out_valid_r;
  logic [15:0] flux_r;
  logic [16:0] contrib [NL];
  logic [2:0]  cnt;
  logic [19:0] sum;
  logic        accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_r  <= 1'b0;
      width_r <= RST_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAMP:  lamp_r  <= cfg_wdata[0];
        REG_WIDTH: width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Widths below the minimum are raised to it before squaring.
  assign eff_width = (width_r < MIN_WIDTH) ? MIN_WIDTH : width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsq_r <= 32'(RST_WIDTH) * 32'(RST_WIDTH);
    end else begin
      wsq_r <= 32'(eff_width) * 32'(eff_width);
    end
  end

  always_ff @(posedge clk) begin
    wl_r <= in_wavelength;
  end

  // Valid bits travel alongside the lane stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LANE_DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i <= LANE_DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  for (genvar k = 0; k < NL; k++) begin : g_lane
    gels_lane #(
      .LANE            (k),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_lane (
      .clk     (clk),
      .lamp    (lamp_r),
      .wl      (wl_r),
      .wsq     (wsq_r),
      .contrib (contrib[k])
    );
  end

  // Contributions are never negative, so clipping the total once gives the
  // same answer as clipping after every addition.
  assign cnt = (32'(LINE_COUNT[lamp_r]) > NL) ? 3'(NL) : LINE_COUNT[lamp_r];

  always_comb begin
    sum = '0;
    for (int k = 0; k < NL; k++) begin
      if (3'(k) < cnt) begin
        sum = sum + 20'(contrib[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[LANE_DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    flux_r <= (sum > 20'd65535) ? 16'hFFFF : sum[15:0];
  end

  assign out_valid = out_valid_r;
  assign out_flux  = flux_r;

endmodule

FILE: rtl/gels_lane.sv
// One line lane: distance, squared ratio by restoring division, exponential and scaling.
module gels_lane import gels_pkg::*; #(
  parameter int unsigned LANE            = 0,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        lamp,
  input  logic [15:0] wl,
  input  logic [31:0] wsq,
  output logic [16:0] contrib
);

  localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  logic [31:0] gtab [EXP_TABLE_DEPTH];
  logic [15:0] centre;
  logic [15:0] diff;
  logic [31:0] dsq_r;
  logic [53:0] num;
  logic [52:0] lim;
  logic [53:0] rem_r [DIV_BITS+1];
  logic [20:0] q_r   [DIV_BITS+1];
  logic        cut_r [DIV_BITS+1];
  logic [31:0] idx_prod;
  logic [31:0] g_r;
  logic [4:0]  n_r;
  logic        cutg_r;
  logic [46:0] prod_r;
  logic [4:0]  np_r;
  logic        cutp_r;
  logic [56:0] rnd;
  logic [56:0] shifted;
  logic [16:0] contrib_r;

  // Entry i: 2^60 / (Q30 e^(i*ln2/depth)), a degree-12 series truncated at every step.
  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_tab
    localparam longint unsigned Z   = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
    localparam longint unsigned S12 = ONE_Q30 + ((ONE_Q30 * Z) >> 30) / 12;
    localparam longint unsigned S11 = ONE_Q30 + ((S12 * Z) >> 30) / 11;
    localparam longint unsigned S10 = ONE_Q30 + ((S11 * Z) >> 30) / 10;
    localparam longint unsigned S9  = ONE_Q30 + ((S10 * Z) >> 30) / 9;
    localparam longint unsigned S8  = ONE_Q30 + ((S9 * Z) >> 30) / 8;
    localparam longint unsigned S7  = ONE_Q30 + ((S8 * Z) >> 30) / 7;
    localparam longint unsigned S6  = ONE_Q30 + ((S7 * Z) >> 30) / 6;
    localparam longint unsigned S5  = ONE_Q30 + ((S6 * Z) >> 30) / 5;
    localparam longint unsigned S4  = ONE_Q30 + ((S5 * Z) >> 30) / 4;
    localparam longint unsigned S3  = ONE_Q30 + ((S4 * Z) >> 30) / 3;
    localparam longint unsigned S2  = ONE_Q30 + ((S3 * Z) >> 30) / 2;
    localparam longint unsigned S1  = ONE_Q30 + ((S2 * Z) >> 30);
    localparam longint unsigned G   = (64'd1 << 60) / S1;
    assign gtab[i] = 32'(G);
  end

  assign centre = LINE_CENTRE[lamp][LANE];
  assign diff   = (wl >= centre) ? (wl - centre) : (centre - wl);

  always_ff @(posedge clk) begin
    dsq_r <= 32'(diff) * 32'(diff);
  end

  // The line is dropped once the exponent reaches 26, about six sigma.
  assign num = {dsq_r, 22'b0};
  assign lim = {37'(wsq) * 37'd26, 16'b0};

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    q_r[0]   <= '0;
    cut_r[0] <= (num >= {1'b0, lim});
  end

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [53:0] sub;
    logic        ge;
    assign sub = {22'b0, wsq} << (DIV_BITS - 1 - j);
    assign ge  = rem_r[j] >= sub;
    always_ff @(posedge clk) begin
      rem_r[j+1] <= ge ? (rem_r[j] - sub) : rem_r[j];
      q_r[j+1]   <= {q_r[j][19:0], ge};
      cut_r[j+1] <= cut_r[j];
    end
  end

  assign idx_prod = 32'(q_r[DIV_BITS][15:0]) * 32'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    g_r    <= gtab[idx_prod[16 +: IDX_W]];
    n_r    <= q_r[DIV_BITS][20:16];
    cutg_r <= cut_r[DIV_BITS];
  end

  always_ff @(posedge clk) begin
    prod_r <= 47'(LINE_GAIN[lamp][LANE]) * 47'(g_r);
    np_r   <= n_r;
    cutp_r <= cutg_r;
  end

  assign rnd     = 57'(prod_r) + (57'd1 << (6'd29 + 6'(np_r)));
  assign shifted = rnd >> (6'd30 + 6'(np_r));

  always_ff @(posedge clk) begin
    contrib_r <= cutp_r ? 17'd0 : shifted[16:0];
  end

  assign contrib = contrib_r;

endmodule

FILE: rtl/gels_chk.sv
// Port-level checker for the line synthesiser and its bind.
module gels_chk import gels_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##GELS_LATENCY out_valid)
    else $error("accepted word produced no result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, GELS_LATENCY))
    else $error("result without an accepted word");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

bind gaussian_emission_line_synth gels_chk u_gels_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

FILE: tb/gaussian_emission_line_synth_tb.sv
// Self-checking testbench for the Gaussian emission-line lamp synthesiser.
module gaussian_emission_line_synth_tb import gels_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // These must match the parameters that the instance is built with.
  localparam int unsigned LINES_USED = 5;
  localparam int unsigned EXP_DEPTH  = 256;

  // Register indexes that decode to nothing; writes there must be ignored.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  // Fixed-point constants of the exponential.
  localparam logic [63:0] LN2_Q30    = 64'd744261118;
  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam int unsigned HORNER_LEN = 12;

  // Cycles without any accepted word or result before the run is declared
  // hung. The slowest correct stretch is the settle pause before a register
  // write plus a few idle gaps.
  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_wavelength;
  logic        out_valid;
  logic [15:0] out_flux;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  gaussian_emission_line_synth #(
    .MAX_LINES       (LINES_USED),
    .EXP_TABLE_DEPTH (EXP_DEPTH)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_wavelength (in_wavelength),
    .out_valid     (out_valid),
    .out_flux      (out_flux),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Our own copy of the configuration, updated as each register is written.
  logic        lamp_now;
  logic [15:0] width_now;

  // 2^(-i/EXP_DEPTH) in Q1.30 for every table index.
  logic [63:0] pow2_frac [EXP_DEPTH];

  // Flux words predicted for accepted wavelengths, oldest first.
  logic [15:0] flux_expected [$];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned cfg_writes;
  int unsigned stall_count;
  bit          gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Builds the fractional exponential table from a truncated series for e^z
  // followed by a reciprocal, exactly as the hardware tables are defined.
  function automatic void build_pow2_table();
    logic [63:0] z;
    logic [63:0] s;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      z = (64'(i) * LN2_Q30) / 64'(EXP_DEPTH);
      s = ONE_Q30;
      for (int k = HORNER_LEN; k >= 1; k--) begin
        s = ONE_Q30 + ((s * z) >> 30) / 64'(k);
      end
      pow2_frac[i] = (64'd1 << 60) / s;
    end
  endfunction

  // Sums the Gaussian contribution of every line of the current lamp at one
  // wavelength. The exponent is y = 64*diff^2/width^2 in Q.16, so that
  // exp(-0.5*d*d) becomes 2^-y: an integer shift and a table fraction.
  function automatic logic [15:0] predict_flux(logic [15:0] wl);
    logic [63:0] w;
    logic [63:0] diff;
    logic [63:0] yq;
    logic [63:0] n;
    logic [63:0] idx;
    logic [63:0] term;
    logic [63:0] centre;
    logic [63:0] gain;
    int unsigned sum;
    int unsigned count;
    w = (width_now < MIN_WIDTH) ? 64'(MIN_WIDTH) : 64'(width_now);
    count = LINE_COUNT[lamp_now];
    if (count > LINES_USED) count = LINES_USED;
    sum = 0;
    for (int k = 0; k < count; k++) begin
      centre = 64'(LINE_CENTRE[lamp_now][k]);
      gain = 64'(LINE_GAIN[lamp_now][k]);
      diff = (64'(wl) >= centre) ? 64'(wl) - centre : centre - 64'(wl);
      yq = ((diff * diff) << 22) / (w * w);
      // Beyond about six sigma a line adds nothing at all.
      if (yq < (64'(CUTOFF_INT) << 16)) begin
        n = yq >> 16;
        idx = ((yq & 64'hFFFF) * 64'(EXP_DEPTH)) >> 16;
        term = (gain * pow2_frac[idx] + (64'd1 << (29 + n))) >> (30 + n);
        sum = sum + int'(term);
        if (sum > 65535) sum = 65535;
      end
    end
    return sum[15:0];
  endfunction

  // Every flux word is compared with the oldest prediction still waiting.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (flux_expected.size() == 0) begin
        $display("%0t: unexpected flux word, expected none, actual %0d", $time, out_flux);
        errors++;
      end else begin
        if (out_flux !== flux_expected[0]) begin
          $display("%0t: flux mismatch, expected %0d, actual %0d",
                   $time, flux_expected[0], out_flux);
          errors++;
        end
        void'(flux_expected.pop_front());
        words_checked++;
      end
    end
  end

  // Watchdog: counts cycles in which no word moves in either direction.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offers one wavelength and holds it until the block takes it. When gaps
  // are enabled, each cycle is left idle with a chance of 29 in a hundred so
  // that idle cycles land on every stage of the pipeline.
  task automatic send_word(input logic [15:0] wl);
    if (gaps_on) begin
      while ($urandom_range(99) < 29) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_wavelength <= wl;
    @(posedge clk);
    while (busy) @(posedge clk);
    flux_expected.push_back(predict_flux(wl));
    words_sent++;
  endtask

  // Drains the pipeline and then writes one register. Every word yields a
  // result, but the settle pause covers the full latency all the same.
  task automatic write_register(input logic [1:0] index, input logic [15:0] value);
    start <= 1'b0;
    while (flux_expected.size() != 0) @(posedge clk);
    repeat (GELS_LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == REG_LAMP) lamp_now = value[0];
    else if (index == REG_WIDTH) width_now = value;
    cfg_writes++;
  endtask

  // Bottom and top of the wavelength range, and the reset configuration.
  task automatic test_extremes();
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h5555);
    send_word(16'hAAAA);
  endtask

  // Some line centres exactly and some one step to one side, for both lamps.
  task automatic test_line_centres();
    send_word(LINE_CENTRE[0][2]);
    send_word(LINE_CENTRE[0][3] + 16'd1);
    send_word(LINE_CENTRE[0][4] - 16'd1);
    send_word(LINE_CENTRE[0][0]);
    write_register(REG_LAMP, 16'd1);
    send_word(LINE_CENTRE[1][0]);
    send_word(LINE_CENTRE[1][2]);
    send_word(LINE_CENTRE[1][3]);
    // The unused fifth slot of the neon table must not contribute.
    send_word(16'd0);
  endtask

  // Narrowest, widest and below-minimum widths, plus words well beyond
  // the six-sigma cut-off for the reset width.
  task automatic test_width_limits();
    write_register(REG_WIDTH, 16'd16);
    send_word(LINE_CENTRE[1][2]);
    send_word(LINE_CENTRE[1][2] + 16'd4);
    write_register(REG_WIDTH, 16'd0);
    send_word(LINE_CENTRE[1][2] + 16'd4);
    write_register(REG_WIDTH, 16'd7);
    send_word(LINE_CENTRE[1][1] - 16'd3);
    write_register(REG_WIDTH, 16'hFFFF);
    send_word(16'h0000);
    send_word(16'hFFFF);
    write_register(REG_WIDTH, RST_WIDTH);
    // Far past the cut-off: diff of about 12.2 nm (Q10.6), over 14 sigma.
    send_word(LINE_CENTRE[1][2] + 16'd783);
    send_word(LINE_CENTRE[1][2] + 16'd784);
  endtask

  // Register decode: bits above the lamp bit are dropped, and writes to
  // indexes outside the register list change nothing.
  task automatic test_register_decode();
    write_register(REG_LAMP, 16'hFFFE);
    send_word(LINE_CENTRE[0][1]);
    write_register(REG_SPARE_A, 16'hFFFF);
    write_register(REG_SPARE_B, 16'h0001);
    send_word(LINE_CENTRE[0][1]);
  endtask

  // Random phases, each with its own lamp and width. Most wavelengths sit
  // within a few line widths of some centre so that the exponent covers its
  // whole range; the rest are spread over the full field.
  task automatic test_random_phases();
    logic [15:0] wl;
    logic [15:0] width;
    int          reach;
    int          offset;
    int          line;
    for (int phase = 0; phase < 10; phase++) begin
      // One phase runs without any idle gaps at all.
      gaps_on = (phase != 4);
      write_register(REG_LAMP, 16'($urandom));
      case ($urandom_range(5))
        0:       width = 16'($urandom_range(0, 15));
        1:       width = 16'($urandom_range(16, 65535));
        default: width = 16'($urandom_range(16, 2048));
      endcase
      if (phase == 0) width = 16'd16;
      if (phase == 9) width = 16'hFFFF;
      write_register(REG_WIDTH, width);
      reach = (width < 16) ? 32 : int'(width) * 2;
      for (int i = 0; i < 165; i++) begin
        if ($urandom_range(99) < 80) begin
          line = $urandom_range(LINE_COUNT[lamp_now] - 1);
          offset = $urandom_range(0, reach);
          if ($urandom_range(1)) offset = -offset;
          offset = offset + int'(LINE_CENTRE[lamp_now][line]);
          if (offset < 0) offset = 0;
          if (offset > 65535) offset = 65535;
          wl = 16'(offset);
        end else begin
          wl = 16'($urandom);
        end
        send_word(wl);
      end
    end
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    cfg_writes = 0;
    stall_count = 0;
    gaps_on = 1'b1;
    lamp_now = 1'b0;
    width_now = RST_WIDTH;
    rst_n = 1'b0;
    start = 1'b0;
    in_wavelength = '0;
    cfg_we = 1'b0;
    cfg_index = REG_LAMP;
    cfg_wdata = '0;
    build_pow2_table();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_line_centres();
    test_width_limits();
    test_register_decode();
    test_random_phases();

    start <= 1'b0;
    while (flux_expected.size() != 0) @(posedge clk);
    repeat (GELS_LATENCY + 8) @(posedge clk);

    $display("Sent %0d wavelength words, checked %0d flux words, %0d register writes.",
             words_sent, words_checked, cfg_writes);
    $display("Both lamps, widths from below the minimum to full scale, random idle gaps.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
